[hdl/gnms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gnms_pkg;

  // size of the kept-box store, one cell per entry
  localparam int unsigned MAX_KEPT = 64;
  localparam int unsigned COUNT_W  = $clog2(MAX_KEPT + 1);
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned THR_W    = 8;

  // 0.45 * 256 rounded down
  localparam logic [THR_W-1:0] THR_RESET = 8'd115;

  // one box with its precomputed area
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [31:0]        area;
  } kbox_t;

  // candidate request travelling down the cell row
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] remain;
    kbox_t              box;
  } cand_t;

endpackage

`default_nettype wire

[hdl/gnms_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module gnms_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [gnms_pkg::THR_W-1:0] thr_i,
  input  wire gnms_pkg::cand_t            cand_i,
  output gnms_pkg::cand_t                 cand_o,
  input  wire logic                       drop_i,
  output logic                            drop_o,
  output logic                            rvalid_o,
  input  wire logic                       shift_i,
  input  wire gnms_pkg::kbox_t            kbox_i,
  output gnms_pkg::kbox_t                 kbox_o
);
  import gnms_pkg::*;

  kbox_t kbox_q;
  cand_t cand_q, cand_d;

  logic signed [17:0] c_l, c_r, c_t, c_b;
  logic signed [17:0] k_l, k_r, k_t, k_b;
  logic signed [17:0] ed_l, ed_r, ed_t, ed_b;
  logic [15:0] iw_d, ih_d;
  logic        act_d;

  logic [15:0] iw1_q, ih1_q;
  logic [31:0] carea1_q;
  logic        act1_q, v1_q;

  logic [31:0] inter2_q;
  logic [32:0] sum2_q;
  logic        act2_q, v2_q;

  logic [31:0] inter3_q;
  logic [32:0] uni3_q;
  logic        act3_q, v3_q;

  logic [40:0] lhs, rhs;
  logic        hit;
  logic        drop_q, rv_q;

  // edges of candidate and stored box, widened so right/bottom cannot wrap
  always_comb begin
    c_l = 18'(cand_i.box.x);
    c_t = 18'(cand_i.box.y);
    c_r = c_l + $signed({2'b00, cand_i.box.w});
    c_b = c_t + $signed({2'b00, cand_i.box.h});
    k_l = 18'(kbox_q.x);
    k_t = 18'(kbox_q.y);
    k_r = k_l + $signed({2'b00, kbox_q.w});
    k_b = k_t + $signed({2'b00, kbox_q.h});
    ed_l = (c_l > k_l) ? c_l : k_l;
    ed_t = (c_t > k_t) ? c_t : k_t;
    ed_r = (c_r < k_r) ? c_r : k_r;
    ed_b = (c_b < k_b) ? c_b : k_b;
  end

  // overlap extent, empty overlap gives zero
  always_comb begin
    iw_d  = (ed_r > ed_l) ? 16'(ed_r - ed_l) : '0;
    ih_d  = (ed_b > ed_t) ? 16'(ed_b - ed_t) : '0;
    act_d = cand_i.valid && (cand_i.remain != '0);
  end

  // ratio test without division: inter*256 > thr*union
  always_comb begin
    lhs = {1'b0, inter3_q, 8'h00};
    rhs = 41'(thr_i) * 41'(uni3_q);
    hit = act3_q && (lhs > rhs);
  end

  // candidate for the neighbor, remaining count steps down
  always_comb begin
    cand_d        = cand_i;
    cand_d.remain = (cand_i.remain == '0) ? '0 : cand_i.remain - 1'b1;
  end

  // stored box, shifted in when a new box is kept
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      kbox_q <= kbox_i;
    end
  end

  // candidate moves one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  // compare pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act1_q <= 1'b0;
      v1_q   <= 1'b0;
      act2_q <= 1'b0;
      v2_q   <= 1'b0;
      act3_q <= 1'b0;
      v3_q   <= 1'b0;
      drop_q <= 1'b0;
      rv_q   <= 1'b0;
    end else begin
      act1_q <= act_d;
      v1_q   <= cand_i.valid;
      act2_q <= act1_q;
      v2_q   <= v1_q;
      act3_q <= act2_q;
      v3_q   <= v2_q;
      drop_q <= drop_i | hit;
      rv_q   <= v3_q;
    end
  end

  // compare pipeline data
  always_ff @(posedge clk_i) begin
    iw1_q    <= iw_d;
    ih1_q    <= ih_d;
    carea1_q <= cand_i.box.area;
    inter2_q <= iw1_q * ih1_q;
    sum2_q   <= {1'b0, carea1_q} + {1'b0, kbox_q.area};
    inter3_q <= inter2_q;
    uni3_q   <= sum2_q - {1'b0, inter2_q};
  end

  assign cand_o   = cand_q;
  assign kbox_o   = kbox_q;
  assign drop_o   = drop_q;
  assign rvalid_o = rv_q;

endmodule

`default_nettype wire

[hdl/greedy_nms_box_filter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// greedy non-maximum suppression over score-sorted boxes
// input channel (in_valid_i / in_ready_o) takes one box per request with
// first/last set flags; output channel (out_valid_o / out_ready_i) returns
// one result per box: keep flag, index within the set, store-full flag, last.
// kept boxes sit in a row of MAX_KEPT cells; a candidate walks the row one
// cell per cycle while each cell runs a four-stage overlap compare against
// its stored box and ORs its hit into a drop flag handed to the next cell.
// one box is in flight at a time: a new request is taken only after the
// previous box has walked the row and left the done state. the result sits
// in an output register: the next request is accepted while it waits; a
// stalled receiver holds the following box in the done state. reset
// clears the kept count, set position and output valid, and loads the
// threshold 115/256; cfg_we_i writes the threshold, and the user must
// write it only while idle, as the block does not enforce it.
// first_of_set clears the store before that box; a kept box that finds the
// store full is reported kept with store_full and not stored.
module greedy_nms_box_filter_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [gnms_pkg::THR_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       first_of_set_i,
  input  wire logic                       last_of_set_i,
  input  wire logic signed [15:0]         box_x_i,
  input  wire logic signed [15:0]         box_y_i,
  input  wire logic [15:0]                box_w_i,
  input  wire logic [15:0]                box_h_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            keep_o,
  output logic [gnms_pkg::INDEX_W-1:0]    box_index_o,
  output logic                            store_full_o,
  output logic                            last_o
);
  import gnms_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_AREA = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0]   thr_q;
  logic [COUNT_W-1:0] count_q;
  logic [INDEX_W-1:0] pos_q, idx_q, idx_d;
  logic               last_q;
  kbox_t              cbox_q;
  cand_t              launch_q;
  logic               drop_res_q;

  logic               out_valid_q, keep_q, full_q, out_last_q;
  logic [INDEX_W-1:0] out_idx_q;

  logic in_fire, fin_fire, keep_fin, room, store_shift;

  cand_t cand_w [MAX_KEPT+1];
  kbox_t kbox_w [MAX_KEPT+1];
  logic  drop_w [MAX_KEPT+1];
  logic  rv_w   [MAX_KEPT];

  // handshake and finish decisions
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    in_fire     = in_valid_i && in_ready_o;
    fin_fire    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    keep_fin    = !drop_res_q;
    room        = (count_q < COUNT_W'(MAX_KEPT));
    store_shift = fin_fire && keep_fin && room;
    idx_d       = first_of_set_i ? '0 : pos_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_AREA;
      end
      ST_AREA: state_d = ST_RUN;
      ST_RUN: begin
        if (rv_w[MAX_KEPT-1]) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (fin_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THR_RESET;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      launch_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pos_q <= idx_d + 1'b1;
        if (first_of_set_i) count_q <= '0;
      end else if (store_shift) begin
        count_q <= count_q + 1'b1;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // launch the candidate into the first cell for one cycle
      launch_q.valid <= (state_q == ST_AREA);
      if (state_q == ST_AREA) begin
        launch_q.remain <= count_q;
        launch_q.box    <= cbox_q;
      end
    end
  end

  // candidate and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cbox_q.x    <= box_x_i;
      cbox_q.y    <= box_y_i;
      cbox_q.w    <= box_w_i;
      cbox_q.h    <= box_h_i;
      cbox_q.area <= {16'h0000, box_w_i} * {16'h0000, box_h_i};
      idx_q       <= idx_d;
      last_q      <= last_of_set_i;
    end
    if ((state_q == ST_RUN) && rv_w[MAX_KEPT-1]) begin
      drop_res_q <= drop_w[MAX_KEPT];
    end
    if (fin_fire) begin
      keep_q     <= keep_fin;
      full_q     <= keep_fin && !room;
      out_idx_q  <= idx_q;
      out_last_q <= last_q;
    end
  end

  // row of store cells
  assign cand_w[0] = launch_q;
  assign kbox_w[0] = launch_q.box;
  assign drop_w[0] = 1'b0;

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    gnms_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .thr_i    (thr_q),
      .cand_i   (cand_w[g]),
      .cand_o   (cand_w[g+1]),
      .drop_i   (drop_w[g]),
      .drop_o   (drop_w[g+1]),
      .rvalid_o (rv_w[g]),
      .shift_i  (store_shift),
      .kbox_i   (kbox_w[g]),
      .kbox_o   (kbox_w[g+1])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign keep_o       = keep_q;
  assign box_index_o  = out_idx_q;
  assign store_full_o = full_q;
  assign last_o       = out_last_q;

  // the tail of the row reports only while a candidate walks it
  a_tail_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_w[MAX_KEPT-1] |-> state_q == ST_RUN)
    else $error("row result outside run state");

  // store never grows past its size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_KEPT))
    else $error("kept count overflow");

  // full is only reported for a kept box
  a_full_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_full_o |-> keep_o)
    else $error("store full on dropped box");

  // store shifts only with room left
  a_shift_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_shift |=> count_q != '0 && $past(count_q) < COUNT_W'(MAX_KEPT))
    else $error("store shift without room");

  // an accepted request passes the area state and then launches into the row
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##1 launch_q.valid)
    else $error("candidate not launched");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import gnms_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;

  // one box request as presented on the input channel
  typedef struct {
    logic               first;
    logic               last;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
  } box_req_t;

  // expected suppression verdict for one box
  typedef struct {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic               full;
    logic               last;
  } verdict_t;

  // how a random box is placed relative to the set or the previous box
  typedef enum int {
    SHAPE_CLUSTER,
    SHAPE_SPREAD,
    SHAPE_WIDE,
    SHAPE_FLAT,
    SHAPE_REPEAT,
    SHAPE_NUDGE
  } shape_e;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [THR_W-1:0]         cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic                     first_of_set_i = 1'b0;
  logic                     last_of_set_i  = 1'b0;
  logic signed [15:0]       box_x_i        = '0;
  logic signed [15:0]       box_y_i        = '0;
  logic [15:0]              box_w_i        = '0;
  logic [15:0]              box_h_i        = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic                     keep_o;
  logic [INDEX_W-1:0]       box_index_o;
  logic                     store_full_o;
  logic                     last_o;

  // suppression state mirrored in the testbench
  logic [THR_W-1:0]   thr_now = THR_RESET;
  longint             kept_x[MAX_KEPT];
  longint             kept_y[MAX_KEPT];
  longint             kept_w[MAX_KEPT];
  longint             kept_h[MAX_KEPT];
  longint             kept_area[MAX_KEPT];
  int unsigned        kept_num = 0;
  logic [INDEX_W-1:0] set_pos  = '0;

  box_req_t box_q[$];
  verdict_t verdict_q[$];
  box_req_t cur_box;
  box_req_t prev_box;
  int       center_x     = 0;
  int       center_y     = 0;
  int       errors       = 0;
  int       gap_left     = 0;
  int       stall_left   = 0;
  int       quiet_cycles = 0;
  bit       in_calm      = 1'b0;
  bit       out_calm     = 1'b0;

  greedy_nms_box_filter_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_of_set_i (first_of_set_i),
    .last_of_set_i  (last_of_set_i),
    .box_x_i        (box_x_i),
    .box_y_i        (box_y_i),
    .box_w_i        (box_w_i),
    .box_h_i        (box_h_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .keep_o         (keep_o),
    .box_index_o    (box_index_o),
    .store_full_o   (store_full_o),
    .last_o         (last_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // greedy suppression decision for one accepted box
  task automatic predict_verdict(input box_req_t b);
    longint   ax, ay, aw, ah, a_area;
    longint   l, t, r, btm, inter, uni;
    logic     drop;
    verdict_t v;
    if (b.first) begin
      kept_num = 0;
      set_pos  = '0;
    end
    v.index = set_pos;
    set_pos = set_pos + 1'b1;
    v.last  = b.last;
    v.full  = 1'b0;
    ax = b.x;
    ay = b.y;
    aw = b.w;
    ah = b.h;
    a_area = aw * ah;
    drop = 1'b0;
    for (int i = 0; i < kept_num; i++) begin
      l   = (ax > kept_x[i]) ? ax : kept_x[i];
      t   = (ay > kept_y[i]) ? ay : kept_y[i];
      r   = (ax + aw < kept_x[i] + kept_w[i]) ? ax + aw : kept_x[i] + kept_w[i];
      btm = (ay + ah < kept_y[i] + kept_h[i]) ? ay + ah : kept_y[i] + kept_h[i];
      inter = (r > l && btm > t) ? (r - l) * (btm - t) : 0;
      uni   = a_area + kept_area[i] - inter;
      if (inter * 256 > longint'(thr_now) * uni) drop = 1'b1;
    end
    v.keep = !drop;
    // survivors go to the store while there is room
    if (!drop) begin
      if (kept_num < MAX_KEPT) begin
        kept_x[kept_num]    = ax;
        kept_y[kept_num]    = ay;
        kept_w[kept_num]    = aw;
        kept_h[kept_num]    = ah;
        kept_area[kept_num] = a_area;
        kept_num++;
      end else begin
        v.full = 1'b1;
      end
    end
    verdict_q = {verdict_q, v};
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 150);
  endfunction

  function automatic shape_e pick_shape(input shape_e base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return base;
    if (r < 78) return SHAPE_WIDE;
    if (r < 85) return SHAPE_FLAT;
    if (r < 95) return SHAPE_REPEAT;
    return SHAPE_NUDGE;
  endfunction

  function automatic box_req_t make_box(input shape_e shape);
    box_req_t b;
    b = prev_box;
    b.first = 1'b0;
    b.last  = 1'b0;
    case (shape)
      SHAPE_CLUSTER: begin
        b.x = 16'(center_x + int'($urandom_range(0, 600)) - 300);
        b.y = 16'(center_y + int'($urandom_range(0, 600)) - 300);
        b.w = 16'($urandom_range(1, 800));
        b.h = 16'($urandom_range(1, 800));
      end
      SHAPE_SPREAD: begin
        b.x = 16'(int'($urandom_range(0, 60000)) - 30000);
        b.y = 16'(int'($urandom_range(0, 60000)) - 30000);
        b.w = 16'($urandom_range(16, 240));
        b.h = 16'($urandom_range(16, 240));
      end
      SHAPE_WIDE: begin
        b.x = 16'($urandom);
        b.y = 16'($urandom);
        b.w = 16'($urandom);
        b.h = 16'($urandom);
      end
      SHAPE_FLAT: begin
        b.x = 16'(center_x + int'($urandom_range(0, 600)) - 300);
        b.y = 16'(center_y + int'($urandom_range(0, 600)) - 300);
        b.w = 16'($urandom_range(0, 800));
        b.h = 16'($urandom_range(0, 800));
        case ($urandom_range(0, 2))
          0: b.w = '0;
          1: b.h = '0;
          default: begin
            b.w = '0;
            b.h = '0;
          end
        endcase
      end
      SHAPE_NUDGE: begin
        b.x = b.x + 16'(int'($urandom_range(0, 8)) - 4);
        b.w = b.w + 16'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic queue_req(input box_req_t b);
    box_q = {box_q, b};
    prev_box = b;
  endtask

  task automatic queue_box(input logic first, input logic last,
                           input int x, input int y, input int w, input int h);
    box_req_t b;
    b.first = first;
    b.last  = last;
    b.x     = x[15:0];
    b.y     = y[15:0];
    b.w     = w[15:0];
    b.h     = h[15:0];
    queue_req(b);
  endtask

  // mostly complete sets of nearby boxes, some stray boxes with random flags
  task automatic queue_random(input int n_items);
    int       made, len;
    box_req_t b;
    shape_e   base;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(66, 90) : $urandom_range(1, 24);
        base = (len > 40) ? SHAPE_SPREAD : SHAPE_CLUSTER;
        center_x = int'($urandom_range(0, 20000)) - 10000;
        center_y = int'($urandom_range(0, 20000)) - 10000;
        for (int k = 0; k < len; k++) begin
          b = make_box(pick_shape(base));
          b.first = (k == 0);
          b.last  = (k == len - 1);
          queue_req(b);
        end
        made += len;
      end else begin
        b = make_box(pick_shape(SHAPE_WIDE));
        b.first = $urandom_range(0, 1);
        b.last  = $urandom_range(0, 1);
        queue_req(b);
        made++;
      end
    end
  endtask

  task automatic pick_idling();
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
  endtask

  // idle means no box pending, none on the wire and no verdict outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (box_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_now = v;
    @(negedge clk_i);
  endtask

  // request driver: pops pending boxes and holds each until taken
  always @(posedge clk_i) begin
    box_req_t nxt;
    logic     take, drive;
    if (rst_ni) begin
      take = in_valid_i && in_ready_o;
      if (take) predict_verdict(cur_box);
      if (!in_valid_i || take) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (box_q.size() > 0) begin
          nxt = box_q.pop_front();
          cur_box = nxt;
          first_of_set_i <= nxt.first;
          last_of_set_i  <= nxt.last;
          box_x_i        <= nxt.x;
          box_y_i        <= nxt.y;
          box_w_i        <= nxt.w;
          box_h_i        <= nxt.h;
          drive = 1'b1;
          gap_left = in_calm ? 0 : idle_len();
        end
        in_valid_i <= drive;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    verdict_t want;
    logic     nxt_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: keep %0d index %0d",
                   $time, keep_o, box_index_o);
        end else begin
          want = verdict_q.pop_front();
          if (keep_o !== want.keep) begin
            errors++;
            $display("%0t: keep expected %0d actual %0d", $time, want.keep, keep_o);
          end
          if (box_index_o !== want.index) begin
            errors++;
            $display("%0t: box_index expected %0d actual %0d",
                     $time, want.index, box_index_o);
          end
          if (store_full_o !== want.full) begin
            errors++;
            $display("%0t: store_full expected %0d actual %0d",
                     $time, want.full, store_full_o);
          end
          if (last_o !== want.last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, last_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (!out_calm && $urandom_range(0, 7) == 0) stall_left = idle_len();
      end
      out_ready_i <= nxt_ready;
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed boxes at the reset threshold
    pick_idling();
    queue_box(1, 0, 0, 0, 160, 160);
    queue_box(0, 0, 0, 0, 160, 160);                   // identical box
    queue_box(0, 0, 80, 0, 160, 160);                  // one third overlap
    queue_box(0, 0, 160, 0, 160, 160);                 // edge touching the first
    queue_box(0, 0, 50, 0, 0, 100);                    // zero width
    queue_box(0, 0, 50, 0, 0, 0);                      // empty union with a flat box
    queue_box(0, 0, -32768, -32768, 65535, 65535);     // largest box
    queue_box(0, 1, 32767, 32767, 65535, 65535);       // corner contact, far edge overflow
    queue_box(0, 0, 0, 0, 160, 160);                   // set continues without first
    queue_box(0, 1, -32768, 32767, 0, 65535);
    queue_box(1, 1, 32767, -32768, 65535, 0);
    queue_box(1, 0, 1000, 1000, 256, 16);
    queue_box(0, 0, 1010, 1000, 116, 16);              // just above the limit
    queue_box(0, 0, 1100, 1000, 115, 16);              // exactly at the limit
    queue_box(0, 0, -200, -200, 150, 150);
    queue_box(0, 0, -180, -190, 150, 150);
    queue_box(0, 1, -32768, -32768, 1, 1);
    wait_idle();

    // threshold extremes
    set_threshold(8'd0);
    pick_idling();
    queue_random(120);
    wait_idle();
    set_threshold(8'd255);
    pick_idling();
    queue_random(120);
    wait_idle();

    // half threshold: containment at the limit, then store overflow
    set_threshold(8'd128);
    pick_idling();
    queue_box(1, 0, 0, 0, 100, 1);
    queue_box(0, 0, 10, 0, 51, 1);
    queue_box(0, 1, 20, 0, 50, 1);
    for (int i = 0; i < 66; i++) queue_box(i == 0, 0, i * 400 - 16000, 0, 200, 200);
    queue_box(0, 0, -16000, 0, 200, 200);              // matches a stored box
    queue_box(0, 1, 64 * 400 - 16000, 0, 200, 200);    // matches a box left out
    queue_box(1, 1, -16000, 0, 200, 200);              // fresh set
    queue_random(100);
    wait_idle();

    repeat (3) begin
      set_threshold(8'($urandom_range(1, 254)));
      pick_idling();
      queue_random(170);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
